// ===== rtl/rsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types, constants, microcode table and character tables for the
// radix string converter.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int ACC_WIDTH   = 64;
  localparam int DIGIT_SLOTS = 64;

  localparam int SLOT_AW  = $clog2(DIGIT_SLOTS);
  localparam int CNT_W    = $clog2(DIGIT_SLOTS + 1);
  localparam int BIT_W    = $clog2(ACC_WIDTH);
  localparam int DIGIT_W  = 6;
  localparam int IN_RAD_W = 6;
  localparam int RADIX_W  = 7;
  localparam int CFG_IDX_W = 2;
  localparam int UPC_W    = 4;

  localparam logic [7:0] SYM_MINUS = 8'd45;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_RADIX  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_RADIX = CFG_IDX_W'(1);

  localparam logic [IN_RAD_W-1:0] INPUT_RADIX_RST  = IN_RAD_W'(10);
  localparam logic [RADIX_W-1:0]  OUTPUT_RADIX_RST = RADIX_W'(16);
  localparam logic [RADIX_W-1:0]  RADIX_MIN        = RADIX_W'(2);
  localparam logic [RADIX_W-1:0]  RADIX_MAX        = RADIX_W'(64);

  // microcode step addresses
  localparam logic [UPC_W-1:0] UPC_IDLE      = UPC_W'(0);
  localparam logic [UPC_W-1:0] UPC_HORNER    = UPC_W'(1);
  localparam logic [UPC_W-1:0] UPC_CONV_INIT = UPC_W'(2);
  localparam logic [UPC_W-1:0] UPC_DIV_START = UPC_W'(3);
  localparam logic [UPC_W-1:0] UPC_DIV_BIT   = UPC_W'(4);
  localparam logic [UPC_W-1:0] UPC_DIV_STORE = UPC_W'(5);
  localparam logic [UPC_W-1:0] UPC_EMIT_RD   = UPC_W'(6);
  localparam logic [UPC_W-1:0] UPC_EMIT_OUT  = UPC_W'(7);
  localparam logic [UPC_W-1:0] UPC_FINISH    = UPC_W'(8);

  typedef enum logic [2:0] {
    OP_NOP,
    OP_HORNER,
    OP_CONV_INIT,
    OP_DIV_START,
    OP_DIV_BIT,
    OP_DIV_STORE,
    OP_EMIT_RD,
    OP_EMIT_OUT
  } rsc_op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_START,
    COND_NOT_LAST,
    COND_DIV_RUN,
    COND_MORE_DIG,
    COND_EMIT_MORE
  } rsc_cond_t;

  typedef struct packed {
    rsc_op_t          op;
    rsc_cond_t        cond;
    logic [UPC_W-1:0] target;
  } rsc_uword_t;

  typedef struct packed {
    rsc_op_t op;
    logic    accept;
    logic    finish;
  } rsc_ctrl_t;

  typedef struct packed {
    logic last_sym;
    logic div_run;
    logic more_dig;
    logic emit_more;
  } rsc_stat_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } rsc_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       negative;
    logic       last_char;
  } rsc_out_t;

  // control store
  function automatic rsc_uword_t ucode_rom(input logic [UPC_W-1:0] upc);
    rsc_uword_t w;
    case (upc)
      UPC_IDLE:      w = '{OP_NOP,       COND_NO_START,  UPC_IDLE};
      UPC_HORNER:    w = '{OP_HORNER,    COND_NOT_LAST,  UPC_IDLE};
      UPC_CONV_INIT: w = '{OP_CONV_INIT, COND_NEXT,      UPC_IDLE};
      UPC_DIV_START: w = '{OP_DIV_START, COND_NEXT,      UPC_IDLE};
      UPC_DIV_BIT:   w = '{OP_DIV_BIT,   COND_DIV_RUN,   UPC_DIV_BIT};
      UPC_DIV_STORE: w = '{OP_DIV_STORE, COND_MORE_DIG,  UPC_DIV_START};
      UPC_EMIT_RD:   w = '{OP_EMIT_RD,   COND_NEXT,      UPC_IDLE};
      UPC_EMIT_OUT:  w = '{OP_EMIT_OUT,  COND_EMIT_MORE, UPC_EMIT_RD};
      UPC_FINISH:    w = '{OP_NOP,       COND_ALWAYS,    UPC_IDLE};
      default:       w = '{OP_NOP,       COND_ALWAYS,    UPC_IDLE};
    endcase
    return w;
  endfunction

  // character to digit value; below '0' the value goes negative and wraps
  function automatic logic signed [8:0] digit_value(input logic [7:0] c);
    logic [8:0] d;
    if (c > 8'd96) begin
      d = {1'b0, c} - 9'd61;
    end else if (c > 8'd64) begin
      d = {1'b0, c} - 9'd55;
    end else begin
      d = {1'b0, c} - 9'd48;
    end
    return signed'(d);
  endfunction

  // 0-9 A-Z a-z then underscore
  function automatic logic [7:0] std_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] c;
    if (d < 6'd10) begin
      c = 8'd48 + {2'b00, d};
    end else if (d < 6'd36) begin
      c = 8'd55 + {2'b00, d};
    end else if (d < 6'd62) begin
      c = 8'd61 + {2'b00, d};
    end else begin
      c = 8'd95;
    end
    return c;
  endfunction

  // base64 alphabet
  function automatic logic [7:0] b64_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] c;
    if (d < 6'd26) begin
      c = 8'd65 + {2'b00, d};
    end else if (d < 6'd52) begin
      c = 8'd71 + {2'b00, d};
    end else if (d < 6'd62) begin
      c = {2'b00, d} - 8'd4;
    end else if (d == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

endpackage

// ===== rtl/rsc_sequencer.sv =====
// ----------------------------------------------------------------------------
// rsc_sequencer
// Step counter over the control store, with conditional jumps on datapath
// status and on the start input.
// ----------------------------------------------------------------------------
module rsc_sequencer
  import rsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  rsc_stat_t stat,
  output logic      busy,
  output rsc_ctrl_t ctrl
);

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  rsc_uword_t       uword;
  logic             take;

  assign uword = ucode_rom(upc_r);
  assign busy  = (upc_r != UPC_IDLE);

  always_comb begin
    case (uword.cond)
      COND_NEXT:      take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_START:  take = !start;
      COND_NOT_LAST:  take = !stat.last_sym;
      COND_DIV_RUN:   take = stat.div_run;
      COND_MORE_DIG:  take = stat.more_dig;
      COND_EMIT_MORE: take = stat.emit_more;
      default:        take = 1'b1;
    endcase
    upc_nxt     = take ? uword.target : upc_r + UPC_W'(1);
    ctrl.op     = uword.op;
    ctrl.accept = (upc_r == UPC_IDLE) && start;
    ctrl.finish = (upc_r == UPC_FINISH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UPC_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ===== rtl/rsc_datapath.sv =====
// ----------------------------------------------------------------------------
// rsc_datapath
// Horner accumulator, bit-serial divider, digit store and output register.
// ----------------------------------------------------------------------------
module rsc_datapath
  import rsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  rsc_ctrl_t           ctrl,
  input  rsc_in_t             in_data,
  input  logic [IN_RAD_W-1:0] in_radix,
  input  logic [RADIX_W-1:0]  out_radix,
  output rsc_stat_t           stat,
  output logic                out_valid,
  output rsc_out_t            out_data
);

  logic [7:0]           sym_r;
  logic                 last_r;
  logic [ACC_WIDTH-1:0] acc_r;
  logic [ACC_WIDTH-1:0] acc_nxt;
  logic                 sign_r;
  logic                 first_r;
  logic [ACC_WIDTH-1:0] quo_r;
  logic [RADIX_W-1:0]   rem_r;
  logic [RADIX_W-1:0]   radix_r;
  logic                 is64_r;
  logic [BIT_W-1:0]     bit_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     cnt_dec;
  logic [DIGIT_W-1:0]   rd_r;
  logic [DIGIT_W-1:0]   mem [DIGIT_SLOTS];
  logic [RADIX_W-1:0]   trial;
  logic                 fits;
  logic [RADIX_W-1:0]   radix_clamp;
  logic                 out_valid_r;
  rsc_out_t             out_r;

  // horner step, multiplier is narrow on one side
  assign acc_nxt = acc_r * {{(ACC_WIDTH - IN_RAD_W){1'b0}}, in_radix}
                 + ACC_WIDTH'(digit_value(sym_r));

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r[RADIX_W-2:0], quo_r[ACC_WIDTH-1]};
  assign fits  = (trial >= radix_r);

  assign cnt_dec = cnt_r - CNT_W'(1);

  always_comb begin
    if (out_radix < RADIX_MIN) begin
      radix_clamp = RADIX_MIN;
    end else if (out_radix > RADIX_MAX) begin
      radix_clamp = RADIX_MAX;
    end else begin
      radix_clamp = out_radix;
    end
  end

  assign stat.last_sym  = last_r;
  assign stat.div_run   = (bit_r != BIT_W'(ACC_WIDTH - 1));
  assign stat.more_dig  = (quo_r != '0) && (cnt_r != CNT_W'(DIGIT_SLOTS - 1));
  assign stat.emit_more = (cnt_r != '0);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      sign_r      <= 1'b0;
      first_r     <= 1'b1;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (ctrl.op == OP_EMIT_OUT);
      case (ctrl.op)
        OP_HORNER: begin
          if (first_r && (sym_r == SYM_MINUS)) begin
            sign_r <= 1'b1;
          end else begin
            acc_r <= acc_nxt;
          end
          first_r <= 1'b0;
        end
        OP_CONV_INIT: begin
          acc_r <= '0;
          cnt_r <= '0;
        end
        OP_DIV_STORE: cnt_r <= cnt_r + CNT_W'(1);
        OP_EMIT_RD:   cnt_r <= cnt_dec;
        default: ;
      endcase
      if (ctrl.finish) begin
        sign_r  <= 1'b0;
        first_r <= 1'b1;
        cnt_r   <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      sym_r  <= in_data.symbol;
      last_r <= in_data.last_symbol;
    end
    case (ctrl.op)
      OP_CONV_INIT: begin
        quo_r   <= acc_r;
        radix_r <= radix_clamp;
        is64_r  <= (radix_clamp == RADIX_MAX);
      end
      OP_DIV_START: begin
        rem_r <= '0;
        bit_r <= '0;
      end
      OP_DIV_BIT: begin
        rem_r <= fits ? trial - radix_r : trial;
        quo_r <= {quo_r[ACC_WIDTH-2:0], fits};
        bit_r <= bit_r + BIT_W'(1);
      end
      OP_EMIT_OUT: begin
        out_r.out_char  <= is64_r ? b64_char(rd_r) : std_char(rd_r);
        out_r.negative  <= sign_r;
        out_r.last_char <= (cnt_r == '0);
      end
      default: ;
    endcase
  end

  // digit store
  always_ff @(posedge clk) begin
    if (ctrl.op == OP_DIV_STORE) begin
      mem[cnt_r[SLOT_AW-1:0]] <= rem_r[DIGIT_W-1:0];
    end
    if (ctrl.op == OP_EMIT_RD) begin
      rd_r <= mem[cnt_dec[SLOT_AW-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(ctrl.op == OP_EMIT_OUT))
    else $error("result strobe without emit step");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(ctrl.op == OP_DIV_BIT) |-> (rem_r < radix_r))
    else $error("remainder not below radix");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DIGIT_SLOTS))
    else $error("digit count beyond store depth");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.accept |-> (cnt_r == '0))
    else $error("request taken with digits pending");
`endif

endmodule

// ===== rtl/radix_string_converter_top.sv =====
// ----------------------------------------------------------------------------
// radix_string_converter_top
// Takes a numeral one character per request, accumulates it by Horner's rule
// and emits it again in the output radix, most significant digit first.
// ----------------------------------------------------------------------------
// a request without last_symbol passes the accept and horner steps, then idles
// last request: accept, horner, init; per digit a division start, one quotient
//   bit a cycle through the 64 bit word and a store; then read and output steps
//   per digit, then finish; longest is radix 2, 64 digits, before busy drops
// results come as one-cycle out_valid strobes; the receiver cannot stall
// synchronous active-low reset: radixes return to 10 and 16, numeral cleared
module radix_string_converter_top
  import rsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  rsc_in_t              in_data,
  // result channel
  output logic                 out_valid,
  output rsc_out_t             out_data,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RADIX_W-1:0]   cfg_wdata
);

  logic [IN_RAD_W-1:0] in_radix_r;
  logic [RADIX_W-1:0]  out_radix_r;
  rsc_ctrl_t           ctrl;
  rsc_stat_t           stat;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_radix_r  <= INPUT_RADIX_RST;
      out_radix_r <= OUTPUT_RADIX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INPUT_RADIX:  in_radix_r  <= cfg_wdata[IN_RAD_W-1:0];
        REG_OUTPUT_RADIX: out_radix_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // step counter and control store
  rsc_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // accumulator, divider, digit store and result register
  rsc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_data   (in_data),
    .in_radix  (in_radix_r),
    .out_radix (out_radix_r),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the radix string converter. Numerals go in one
// character per request, and a scoreboard class keeps its own accumulator and
// radix settings, predicts every emitted digit and checks the out_valid
// strobes in order. Directed numerals come first: boundary characters, minus
// handling, and clamped or masked radixes. Random numerals follow, written
// between radix changes.
// ----------------------------------------------------------------------------
module tb_top
  import rsc_pkg::*;
();

  // register slots past the two real ones, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam int RANDOM_REQUESTS = 128;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int IDLE_PCT        = 12;

  // tracks the numeral in flight and holds the digits still to come
  class digit_scoreboard;
    rsc_out_t            pending_digits[$];
    logic [63:0]         acc;
    logic                neg;
    logic                fresh;
    logic [IN_RAD_W-1:0] in_radix;
    logic [RADIX_W-1:0]  out_radix;
    int                  errors;
    int                  digits_checked;
    string std_glyphs = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz__";
    string b64_glyphs = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    function new();
      acc            = '0;
      neg            = 1'b0;
      fresh          = 1'b1;
      in_radix       = INPUT_RADIX_RST;
      out_radix      = OUTPUT_RADIX_RST;
      errors         = 0;
      digits_checked = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [RADIX_W-1:0] val);
      case (idx)
        REG_INPUT_RADIX:  in_radix  = val[IN_RAD_W-1:0];
        REG_OUTPUT_RADIX: out_radix = val;
        default: ;
      endcase
    endfunction

    function void note_request(rsc_in_t req);
      logic [63:0]        dval;
      logic [63:0]        v;
      logic [63:0]        r;
      logic [DIGIT_W-1:0] digs[DIGIT_SLOTS];
      int                 n;
      int                 i;
      rsc_out_t           e;
      if (req.symbol > 8'd96) begin
        dval = 64'(req.symbol) - 64'd61;
      end else if (req.symbol > 8'd64) begin
        dval = 64'(req.symbol) - 64'd55;
      end else begin
        dval = 64'(req.symbol) - 64'd48;
      end
      if (fresh && req.symbol == SYM_MINUS) begin
        neg = 1'b1;
      end else begin
        acc = acc * 64'(in_radix) + dval;
      end
      fresh = 1'b0;
      if (!req.last_symbol) return;
      if (out_radix < RADIX_MIN) begin
        r = 64'(RADIX_MIN);
      end else if (out_radix > RADIX_MAX) begin
        r = 64'(RADIX_MAX);
      end else begin
        r = 64'(out_radix);
      end
      v = acc;
      n = 0;
      do begin
        digs[n] = DIGIT_W'(v % r);
        n++;
        v = v / r;
      end while (v != 0 && n < DIGIT_SLOTS);
      for (i = n - 1; i >= 0; i--) begin
        e.out_char  = (r == 64'(RADIX_MAX)) ? b64_glyphs[digs[i]] : std_glyphs[digs[i]];
        e.negative  = neg;
        e.last_char = (i == 0);
        pending_digits.push_back(e);
      end
      acc   = '0;
      neg   = 1'b0;
      fresh = 1'b1;
    endfunction

    function void check_result(rsc_out_t got);
      rsc_out_t want;
      if (pending_digits.size() == 0) begin
        $error("unexpected result: out_char %0h negative %0b last_char %0b",
               got.out_char, got.negative, got.last_char);
        errors++;
        return;
      end
      want = pending_digits.pop_front();
      digits_checked++;
      if (got.out_char !== want.out_char) begin
        $error("out_char: expected %0h, actual %0h", want.out_char, got.out_char);
        errors++;
      end
      if (got.negative !== want.negative) begin
        $error("negative: expected %0b, actual %0b", want.negative, got.negative);
        errors++;
      end
      if (got.last_char !== want.last_char) begin
        $error("last_char: expected %0b, actual %0b", want.last_char, got.last_char);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  rsc_in_t              in_data;
  logic                 out_valid;
  rsc_out_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RADIX_W-1:0]   cfg_wdata;

  digit_scoreboard sb = new();

  logic [7:0] numeral_q[$];   // characters of the next numeral to send
  int         requests;       // symbol requests accepted so far
  int         numerals_sent;
  bit         no_gaps;        // set during the stretch without sender idling

  radix_string_converter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // every strobe is a result; the receiver has no way to stall it
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_data);
    end
  end

  // one symbol request, with random idle cycles in front of it unless no_gaps is set
  task automatic send_symbol(input logic [7:0] sym, input logic last);
    rsc_in_t req;
    req.symbol      = sym;
    req.last_symbol = last;
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start   = 1'b1;
    in_data = req;
    // accepted at the first rising edge that sees busy low
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(req);
    requests++;
  endtask

  // send numeral_q, last flag on the final character
  task automatic send_numeral();
    int k;
    for (k = 0; k < numeral_q.size(); k++) begin
      send_symbol(numeral_q[k], k == numeral_q.size() - 1);
    end
    @(negedge clk);
    start = 1'b0;
    numerals_sent++;
  endtask

  task automatic send_text(input string s);
    int k;
    numeral_q.delete();
    for (k = 0; k < s.len(); k++) numeral_q.push_back(s[k]);
    send_numeral();
  endtask

  // hold off until every predicted digit has come and the block went idle
  task automatic wait_drained();
    int waited;
    waited = 0;
    while (sb.pending_digits.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending_digits.size() != 0) begin
      $error("%0d expected digits never arrived", sb.pending_digits.size());
      sb.errors++;
      sb.pending_digits.delete();
    end
    while (busy) @(posedge clk);
    // busy stays up through the finish step after the last digit, give it a short margin
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RADIX_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.note_config(idx, val);
  endtask

  // watchdog
  initial begin
    #10000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int                  directed;
    int                  random_requests;
    int                  len;
    int                  k;
    int                  dv;
    int                  top;
    bit                  wellformed;
    logic [IN_RAD_W-1:0] in6;
    logic [RADIX_W-1:0]  out7;

    start         = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    requests      = 0;
    numerals_sent = 0;
    no_gaps       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ---------------- directed part ----------------
    // reset radixes, decimal in and hex out
    send_text("255");
    // lone minus gives a single zero digit flagged negative
    send_text("-");
    send_text("-7");
    // minus after the first character runs through the digit formula and wraps
    send_text("1-");
    wait_drained();

    // widest input radix, base64 alphabet out; characters at the mapping borders
    write_reg(REG_INPUT_RADIX, RADIX_W'(62));
    write_reg(REG_OUTPUT_RADIX, RADIX_W'(64));
    numeral_q = '{8'd64, 8'd65, 8'd96, 8'd97};
    send_numeral();
    numeral_q = '{8'd255};
    send_numeral();
    wait_drained();

    // bit 6 is dropped from the input radix, so this is radix zero;
    // output radix 1 clamps up to binary
    write_reg(REG_INPUT_RADIX, RADIX_W'(64));
    write_reg(REG_OUTPUT_RADIX, RADIX_W'(1));
    // nul wraps far below zero, the top bit is set and all 64 digits come out
    numeral_q = '{8'd0};
    send_numeral();
    send_text("57");
    wait_drained();

    // top of both fields, output clamps down to base64; spare indexes ignored
    write_reg(REG_INPUT_RADIX, RADIX_W'(127));
    write_reg(REG_OUTPUT_RADIX, RADIX_W'(127));
    write_reg(REG_SPARE_A, RADIX_W'(5));
    write_reg(REG_SPARE_B, RADIX_W'(0));
    send_text("-zz");
    wait_drained();

    write_reg(REG_INPUT_RADIX, RADIX_W'(2));
    write_reg(REG_OUTPUT_RADIX, RADIX_W'(65));
    send_text("-Z");
    wait_drained();
    write_reg(REG_OUTPUT_RADIX, RADIX_W'(0));
    send_text("1");

    // ---------------- random part ----------------
    directed        = requests;
    random_requests = 0;
    while (random_requests < RANDOM_REQUESTS) begin
      wait_drained();
      // mostly legal radixes, now and then the edges and out-of-range codes
      if ($urandom_range(0, 99) < 80) begin
        in6 = IN_RAD_W'($urandom_range(2, 62));
      end else begin
        case ($urandom_range(0, 3))
          0:       in6 = IN_RAD_W'(0);
          1:       in6 = IN_RAD_W'(1);
          2:       in6 = IN_RAD_W'(63);
          default: in6 = ($urandom_range(0, 1) != 0) ? IN_RAD_W'(2) : IN_RAD_W'(62);
        endcase
      end
      if ($urandom_range(0, 99) < 80) begin
        out7 = RADIX_W'($urandom_range(2, 64));
      end else begin
        case ($urandom_range(0, 3))
          0:       out7 = RADIX_W'($urandom_range(0, 1));
          1:       out7 = RADIX_W'(65);
          2:       out7 = RADIX_W'(127);
          default: out7 = RADIX_W'($urandom_range(65, 126));
        endcase
      end
      // upper data bit is noise for the input radix
      write_reg(REG_INPUT_RADIX, {1'($urandom_range(0, 1)), in6});
      write_reg(REG_OUTPUT_RADIX, out7);
      if ($urandom_range(0, 9) == 0) begin
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                  RADIX_W'($urandom_range(0, 127)));
      end

      repeat ($urandom_range(1, 4)) begin
        random_requests = requests - directed;
        no_gaps = (random_requests >= 40 && random_requests < 100);
        numeral_q.delete();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        wellformed = ($urandom_range(0, 99) < 75);
        if (wellformed) begin
          // legal digits of the current input radix, 0 and 1 below radix 2, sometimes signed
          if ($urandom_range(0, 2) == 0) numeral_q.push_back(SYM_MINUS);
          top = (in6 < 2) ? 1 : ((in6 > 62) ? 61 : int'(in6) - 1);
          for (k = 0; k < len; k++) begin
            dv = $urandom_range(0, top);
            numeral_q.push_back(8'((dv < 10) ? 48 + dv : ((dv < 36) ? 55 + dv : 61 + dv)));
          end
        end else begin
          // any byte, with stray minus signs sprinkled in
          for (k = 0; k < len; k++) begin
            numeral_q.push_back(($urandom_range(0, 4) == 0) ? SYM_MINUS
                                                            : 8'($urandom_range(0, 255)));
          end
        end
        send_numeral();
        // one explicit hold-off until the block has emptied
        if (numerals_sent == 12) wait_drained();
      end
      random_requests = requests - directed;
    end

    // ---------------- wind down ----------------
    no_gaps = 1'b0;
    wait_drained();
    repeat (16) @(posedge clk);

    $display("run: %0d numerals from %0d symbol requests, %0d digits checked",
             numerals_sent, requests, sb.digits_checked);
    $display("radixes covered in-range, masked and clamped settings plus base64 output");
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rsc_pkg.sv
rtl/rsc_sequencer.sv
rtl/rsc_datapath.sv
rtl/radix_string_converter_top.sv
bench/tb_top.sv
